// ===== rtl/wireworld_grid_engine_assert.svh =====
// Assertion macros used by the grid engine top file.
`ifndef WIREWORLD_GRID_ENGINE_ASSERT_SVH
`define WIREWORLD_GRID_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WGE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WGE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/wwge_pkg.sv =====
// Shared constants, types and functions of the Wireworld grid engine.
package wwge_pkg;

   localparam int GRID_SIZE = 64;
   localparam int NUM_CELLS = GRID_SIZE * GRID_SIZE;
   localparam int CELL_W    = $clog2(NUM_CELLS);
   localparam int POS_W     = $clog2(NUM_CELLS + GRID_SIZE + 1);
   localparam int RC_W      = $clog2(GRID_SIZE);

   localparam logic [1:0] CELL_EMPTY = 2'd0;
   localparam logic [1:0] CELL_HEAD  = 2'd1;
   localparam logic [1:0] CELL_TAIL  = 2'd2;
   localparam logic [1:0] CELL_WIRE  = 2'd3;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_STEP  = 2'd2;

   typedef struct packed {
      logic clr_en;
      logic wr_en;
      logic rd_en;
      logic step_go;
      logic rsp_load;
      logic rsp_sel_read;
      logic rsp_oor;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic step_done;
      logic req_oor;
   } sts_type;

   function automatic logic [1:0] next_cell(input logic [1:0] s, input logic [3:0] heads);
      logic [1:0] n;
      n = s;
      case (s)
         CELL_HEAD: n = CELL_TAIL;
         CELL_TAIL: n = CELL_WIRE;
         CELL_WIRE: n = (heads == 4'd1 || heads == 4'd2) ? CELL_HEAD : CELL_WIRE;
         default:   n = CELL_EMPTY;
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/wwge_ctrl.sv =====
// Controller state machine of the Wireworld grid engine.
module wwge_ctrl
   import wwge_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic [1:0] req_action,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  sts_type    sts,
   output cmd_type    cmd
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_READ  = 2'd2;
   localparam logic [1:0] S_STEP  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (sts.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_WRITE: begin
                     cmd.wr_en    = !sts.req_oor;
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_oor  = sts.req_oor;
                  end
                  ACT_READ: begin
                     if (sts.req_oor) begin
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_oor  = 1'b1;
                     end else begin
                        cmd.rd_en = 1'b1;
                        state_in  = S_READ;
                     end
                  end
                  ACT_STEP: begin
                     cmd.step_go = 1'b1;
                     state_in    = S_STEP;
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            cmd.rsp_load     = 1'b1;
            cmd.rsp_sel_read = 1'b1;
            state_in         = S_IDLE;
         end
         S_STEP: begin
            if (sts.step_done) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/wwge_datapath.sv =====
// Datapath of the Wireworld grid engine: grid memory, sweep pipeline, result register.
module wwge_datapath
   import wwge_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output sts_type    sts,
   input  logic [7:0] req_col,
   input  logic [7:0] req_row,
   input  logic [1:0] req_new_state,
   output logic [1:0] cell_state,
   output logic       out_of_range
);

   localparam int SR_LEN = 2 * GRID_SIZE + 3;
   localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(NUM_CELLS - 1);
   localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(NUM_CELLS + GRID_SIZE);
   localparam logic [POS_W-1:0]  POS_CELLS = POS_W'(NUM_CELLS);
   localparam logic [POS_W-1:0]  POS_LAG   = POS_W'(GRID_SIZE + 1);
   localparam logic [RC_W-1:0]   LAST_RC   = RC_W'(GRID_SIZE - 1);
   localparam logic [8:0]        COORD_LIM = 9'(GRID_SIZE);

   // Two banks: the current generation and the one being built.
   logic [1:0]        mem_ff [0:2*NUM_CELLS-1];
   logic [1:0]        rdata_ff;
   logic              bank_ff;

   logic [CELL_W-1:0] clr_ff;
   logic [POS_W-1:0]  ra_ff;
   logic              ra_run_ff;
   logic              b_v_ff;
   logic [POS_W-1:0]  b_pos_ff;
   logic              c_v_ff;
   logic [POS_W-1:0]  c_pos_ff;
   logic [RC_W-1:0]   ccol_ff;
   logic [RC_W-1:0]   crow_ff;
   logic [1:0]        sr_ff [0:SR_LEN-1];
   logic [1:0]        state_ff;
   logic              oor_ff;

   logic [CELL_W-1:0] req_idx;
   logic [POS_W-1:0]  center_pos;
   logic              c_write;
   logic [3:0]        heads;
   logic              top_e, bot_e, lft_e, rgt_e;
   logic              wr_do;
   logic [CELL_W:0]   wr_addr;
   logic [1:0]        wr_data;
   logic              rd_do;
   logic [CELL_W:0]   rd_addr;

   function automatic logic [3:0] hd(input logic [1:0] s, input logic ok);
      return {3'b000, ok && (s == CELL_HEAD)};
   endfunction

   assign req_idx     = CELL_W'(32'(req_row) * GRID_SIZE + 32'(req_col));
   assign sts.req_oor = ({1'b0, req_col} >= COORD_LIM) || ({1'b0, req_row} >= COORD_LIM);
   assign sts.clr_done  = (clr_ff == LAST_CELL);
   assign sts.step_done = c_v_ff && (c_pos_ff == LAST_POS);

   assign center_pos = c_pos_ff - POS_LAG;
   assign c_write    = c_v_ff && (c_pos_ff >= POS_LAG);

   assign top_e = (crow_ff == '0);
   assign bot_e = (crow_ff == LAST_RC);
   assign lft_e = (ccol_ff == '0);
   assign rgt_e = (ccol_ff == LAST_RC);

   // Newest cell sits at the low end of the shift line.
   assign heads = hd(sr_ff[0], !bot_e && !rgt_e) + hd(sr_ff[1], !bot_e)
                + hd(sr_ff[2], !bot_e && !lft_e) + hd(sr_ff[GRID_SIZE], !rgt_e)
                + hd(sr_ff[GRID_SIZE+2], !lft_e)
                + hd(sr_ff[2*GRID_SIZE], !top_e && !rgt_e)
                + hd(sr_ff[2*GRID_SIZE+1], !top_e)
                + hd(sr_ff[2*GRID_SIZE+2], !top_e && !lft_e);

   always_comb begin
      wr_do   = 1'b0;
      wr_addr = {1'b0, clr_ff};
      wr_data = CELL_EMPTY;
      if (cmd.clr_en) begin
         wr_do = 1'b1;
      end else if (cmd.wr_en) begin
         wr_do   = 1'b1;
         wr_addr = {bank_ff, req_idx};
         wr_data = req_new_state;
      end else if (c_write) begin
         wr_do   = 1'b1;
         wr_addr = {!bank_ff, center_pos[CELL_W-1:0]};
         wr_data = next_cell(sr_ff[GRID_SIZE+1], heads);
      end
   end

   always_comb begin
      rd_do   = 1'b0;
      rd_addr = {bank_ff, req_idx};
      if (cmd.rd_en) begin
         rd_do = 1'b1;
      end else if (ra_run_ff && (ra_ff < POS_CELLS)) begin
         rd_do   = 1'b1;
         rd_addr = {bank_ff, ra_ff[CELL_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_do) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_do) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff    <= '0;
         ra_run_ff <= 1'b0;
         b_v_ff    <= 1'b0;
         c_v_ff    <= 1'b0;
         bank_ff   <= 1'b0;
      end else begin
         if (cmd.clr_en) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.step_go) begin
            ra_run_ff <= 1'b1;
         end else if (ra_run_ff && (ra_ff == LAST_POS)) begin
            ra_run_ff <= 1'b0;
         end
         b_v_ff <= ra_run_ff;
         c_v_ff <= b_v_ff;
         if (sts.step_done) begin
            bank_ff <= !bank_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step_go) begin
         ra_ff   <= '0;
         ccol_ff <= '0;
         crow_ff <= '0;
      end else begin
         if (ra_run_ff) begin
            ra_ff <= ra_ff + 1'b1;
         end
         if (c_write) begin
            if (ccol_ff == LAST_RC) begin
               ccol_ff <= '0;
               crow_ff <= crow_ff + 1'b1;
            end else begin
               ccol_ff <= ccol_ff + 1'b1;
            end
         end
      end
      b_pos_ff <= ra_ff;
      c_pos_ff <= b_pos_ff;
      if (b_v_ff) begin
         sr_ff[0] <= (b_pos_ff < POS_CELLS) ? rdata_ff : CELL_EMPTY;
         for (int i = 1; i < SR_LEN; i++) begin
            sr_ff[i] <= sr_ff[i-1];
         end
      end
      if (cmd.rsp_load) begin
         state_ff <= cmd.rsp_sel_read ? rdata_ff : CELL_EMPTY;
         oor_ff   <= cmd.rsp_oor;
      end
   end

   assign cell_state   = state_ff;
   assign out_of_range = oor_ff;

endmodule

// ===== rtl/wireworld_grid_engine.sv =====
// A write, an unused action or an out-of-grid request answers in the cycle after acceptance.
// A read loads the result register after the grid memory read, which is registered.
// A step sweeps the grid one cell per cycle through a two-row shift line and answers when
// the sweep is done; one request is in work at a time.
// Reset clears control state, then a clearing pass writes GRID_SIZE*GRID_SIZE cells during
// which no request is accepted.
`include "wireworld_grid_engine_assert.svh"

module wireworld_grid_engine
   import wwge_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // action[1:0], col[9:2], row[17:10], new_state[19:18]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // cell_state[1:0], out_of_range[2]
);

   // The controller sequences requests; the datapath owns the grid and the sweep.
   cmd_type    cmd;
   sts_type    sts;
   logic [1:0] cell_state;
   logic       out_of_range;
   logic       req_take;
   logic       take_step;
   logic       take_read;

   wwge_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tdata[1:0]),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   wwge_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_col       (req_tdata[9:2]),
      .req_row       (req_tdata[17:10]),
      .req_new_state (req_tdata[19:18]),
      .cell_state    (cell_state),
      .out_of_range  (out_of_range)
   );

   assign rsp_tdata = {5'b00000, out_of_range, cell_state};

   // Accepted requests, split by kind, for the checks below.
   assign req_take  = req_tvalid && req_tready;
   assign take_step = req_take && (req_tdata[1:0] == ACT_STEP);
   assign take_read = req_take && (req_tdata[1:0] == ACT_READ) && !sts.req_oor;

   // A new request never overwrites a result that is still waiting.
   `WGE_ASSERT_SAME(a_no_overrun, rsp_tvalid && !rsp_tready, !req_tready, "result overrun")
   // A step keeps the input closed in the cycle after it is taken.
   `WGE_ASSERT_NEXT(a_step_busy, take_step, !req_tready, "step did not hold off requests")
   // A read result is not shown before the memory data is back.
   `WGE_ASSERT_NEXT(a_read_wait, take_read, !rsp_tvalid, "read answered too early")

endmodule
